### hdl/katm_pkg.sv
// ============================================================================
// katm_pkg
// Shared types and constants for the keyed accumulate table.
// ============================================================================
package katm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // One item passed from the front end to the table engine
    typedef struct packed {
        logic        op;
        logic [31:0] item_key;
        logic [31:0] item_value;
    } katm_item_t;

    // One result item
    typedef struct packed {
        logic        dropped;
        logic        is_empty;
        logic [31:0] max_value;
        logic [31:0] max_key;
        logic [4:0]  entry_count;
    } katm_result_t;

endpackage

### hdl/katm_front.sv
// ============================================================================
// katm_front
// Input stage and two-entry queue decoupling the stream from the engine.
// ============================================================================
module katm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  katm_pkg::katm_item_t in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output katm_pkg::katm_item_t q_item
);

    katm_pkg::katm_item_t slot_reg [katm_pkg::QUEUE_DEPTH];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           fill_reg;
    logic                 push;
    logic                 pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

### hdl/katm_engine.sv
// ============================================================================
// katm_engine
// Table update and max scan; one entry visited per cycle.
// ============================================================================
module katm_engine
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  katm_pkg::katm_item_t   q_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output katm_pkg::katm_result_t res_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;
    localparam logic [katm_pkg::IDX_W-1:0] LAST_IDX =
        katm_pkg::IDX_W'(katm_pkg::TABLE_DEPTH - 1);

    logic [31:0]                  key_mem [katm_pkg::TABLE_DEPTH];
    logic [31:0]                  tot_mem [katm_pkg::TABLE_DEPTH];
    logic [katm_pkg::TABLE_DEPTH-1:0] used_reg;
    logic [katm_pkg::CNT_W-1:0]   count_reg;

    logic [1:0]                   state_reg;
    logic [katm_pkg::IDX_W-1:0]   idx_reg;
    katm_pkg::katm_item_t         item_reg;
    logic                         found_reg;
    logic                         free_ok_reg;
    logic [katm_pkg::IDX_W-1:0]   free_idx_reg;
    logic                         have_reg;
    logic [31:0]                  best_key_reg;
    logic [31:0]                  best_val_reg;
    logic                         dropped_reg;
    katm_pkg::katm_result_t       res_reg;

    logic [31:0] rd_key;
    logic [31:0] rd_tot;
    logic        hit;
    logic        better;

    assign rd_key  = key_mem[idx_reg];
    assign rd_tot  = tot_mem[idx_reg];
    assign hit     = used_reg[idx_reg] && !found_reg && (rd_key == item_reg.item_key);
    assign better  = !have_reg || ($signed(best_val_reg) < $signed(rd_tot)) ||
                     ((best_val_reg == rd_tot) && ($signed(rd_key) < $signed(best_key_reg)));
    assign q_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res_data  = res_reg;

    // Table storage writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEARCH)
        begin
            if (hit)
            begin
                tot_mem[idx_reg] <= rd_tot + item_reg.item_value;
            end
            else if (idx_reg == LAST_IDX && !found_reg)
            begin
                // New key goes to the first free entry, possibly the last one
                if (free_ok_reg)
                begin
                    key_mem[free_idx_reg] <= item_reg.item_key;
                    tot_mem[free_idx_reg] <= item_reg.item_value;
                end
                else if (!used_reg[idx_reg])
                begin
                    key_mem[idx_reg] <= item_reg.item_key;
                    tot_mem[idx_reg] <= item_reg.item_value;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_SCAN && used_reg[idx_reg] && better)
        begin
            best_key_reg <= rd_key;
            best_val_reg <= rd_tot;
        end
        if (state_reg == ST_SCAN && idx_reg == LAST_IDX)
        begin
            res_reg.entry_count <= 5'(count_reg);
            res_reg.dropped     <= dropped_reg;
            if (have_reg || (used_reg[idx_reg]))
            begin
                res_reg.is_empty  <= 1'b0;
                res_reg.max_key   <= (used_reg[idx_reg] && better) ? rd_key : best_key_reg;
                res_reg.max_value <= (used_reg[idx_reg] && better) ? rd_tot : best_val_reg;
            end
            else
            begin
                res_reg.is_empty  <= 1'b1;
                res_reg.max_key   <= 32'd0;
                res_reg.max_value <= 32'd0;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            used_reg     <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
            have_reg     <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg     <= '0;
                    found_reg   <= 1'b0;
                    free_ok_reg <= 1'b0;
                    have_reg    <= 1'b0;
                    dropped_reg <= 1'b0;
                    if (q_valid)
                    begin
                        if (q_item.op == katm_pkg::OP_CLEAR)
                        begin
                            used_reg  <= '0;
                            count_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!used_reg[idx_reg] && !free_ok_reg)
                    begin
                        free_ok_reg  <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                        if (!found_reg && !hit)
                        begin
                            if (free_ok_reg)
                            begin
                                used_reg[free_idx_reg] <= 1'b1;
                                count_reg <= count_reg + 1'b1;
                            end
                            else if (!used_reg[idx_reg])
                            begin
                                used_reg[idx_reg] <= 1'b1;
                                count_reg <= count_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_reg <= 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (used_reg[idx_reg])
                    begin
                        have_reg <= 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/keyed_accumulate_table_with_max_unit.sv
// ============================================================================
// keyed_accumulate_table_with_max_unit
// Keyed accumulate table reporting entry count and largest-valued entry.
// ============================================================================
// Usage:
//   Input requests arrive on s_axis_*: tuser carries op (0 add, 1 clear),
//   tdata carries item_key then item_value. Each request gives exactly one
//   result request on m_axis_* with entry_count, max_key, max_value,
//   is_empty and dropped.
//   A two-entry queue holds incoming requests while the engine works.
//   The engine visits one table entry per cycle: an add first searches
//   and updates the table, then scans it to find the max; a clear only
//   scans. The engine takes no new request from the queue until its
//   result has been taken. The single table port sets this rate.
//   At reset the table and the queue are empty.
//   If the receiver holds m_axis_tready low, the result waits in its
//   register; the queue keeps taking up to two further requests.
//   A new key arriving at a full table is refused and dropped is set.
// ============================================================================
module keyed_accumulate_table_with_max_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // item_key[31:0], item_value[63:32]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // entry_count[4:0], max_key[36:5],
                                        // max_value[68:37], is_empty[69],
                                        // dropped[70], zero[71]
);

    katm_pkg::katm_item_t   in_item;
    katm_pkg::katm_item_t   q_item;
    katm_pkg::katm_result_t res;
    logic                   q_valid;
    logic                   q_ready;

    assign in_item.op         = s_axis_tuser;
    assign in_item.item_key   = s_axis_tdata[31:0];
    assign in_item.item_value = s_axis_tdata[63:32];

    katm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    katm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res)
    );

    assign m_axis_tdata = {1'b0, res};

    // Empty result carries zero max fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[69]) |-> (m_axis_tdata[68:5] == 64'd0))
        else $error("empty result with nonzero max");

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'(katm_pkg::TABLE_DEPTH)))
        else $error("entry count beyond capacity");

    // Empty flag agrees with count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[69] == (m_axis_tdata[4:0] == 5'd0)))
        else $error("empty flag disagrees with count");

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb - keyed accumulate table with max
// Drives add and clear requests over the input stream, predicts count, max
// entry, empty and dropped for each one, and compares every result request.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1450;
    localparam int CYC_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // item_key[31:0], item_value[63:32]
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // entry_count, max_key, max_value, is_empty, dropped

    keyed_accumulate_table_with_max_unit u_top (.*);

    // Predictor state
    logic [31:0] tbl_key   [katm_pkg::TABLE_DEPTH];
    logic [31:0] tbl_total [katm_pkg::TABLE_DEPTH];
    logic        tbl_used  [katm_pkg::TABLE_DEPTH];
    int          tbl_count;

    katm_pkg::katm_result_t result_q[$];
    int  errors;
    int  cycles;
    bit  stim_done;

    // Directed table; check_fixed rows carry a literal expected result
    typedef struct {
        logic                   op;
        logic [31:0]            k;
        logic [31:0]            v;
        bit                     check_fixed;
        katm_pkg::katm_result_t fixed;
    } dir_row_t;
    dir_row_t dir_rows[$];

    // Pool of keys for frequent matches
    logic [31:0] key_pool[8];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic katm_pkg::katm_result_t predict_table(logic op, logic [31:0] k,
                                                             logic [31:0] v);
        katm_pkg::katm_result_t r;
        bit found;
        int free_idx;
        bit have;
        r = '0;
        found = 0;
        free_idx = -1;
        have = 0;
        if (op == katm_pkg::OP_CLEAR) begin
            for (int i = 0; i < katm_pkg::TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
            tbl_count = 0;
        end
        else begin
            for (int i = 0; i < katm_pkg::TABLE_DEPTH; i++) begin
                if (tbl_used[i]) begin
                    if (!found && tbl_key[i] == k) begin
                        tbl_total[i] = tbl_total[i] + v;
                        found = 1;
                    end
                end
                else if (free_idx < 0) free_idx = i;
            end
            if (!found) begin
                if (free_idx >= 0) begin
                    tbl_used[free_idx]  = 1'b1;
                    tbl_key[free_idx]   = k;
                    tbl_total[free_idx] = v;
                    tbl_count++;
                end
                else r.dropped = 1'b1;
            end
        end
        // Largest total, smaller key on ties
        for (int i = 0; i < katm_pkg::TABLE_DEPTH; i++) begin
            if (tbl_used[i]) begin
                if (!have || $signed(r.max_value) < $signed(tbl_total[i]) ||
                    (r.max_value == tbl_total[i] && $signed(tbl_key[i]) < $signed(r.max_key)))
                begin
                    r.max_key   = tbl_key[i];
                    r.max_value = tbl_total[i];
                    have = 1;
                end
            end
        end
        r.entry_count = tbl_count[4:0];
        r.is_empty    = !have;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(logic op, logic [31:0] k, logic [31:0] v,
                                bit check_fixed, katm_pkg::katm_result_t fixed);
        katm_pkg::katm_result_t exp_r;
        int g;
        g = gap_len();
        repeat (g) @(negedge clk) s_axis_tvalid <= 1'b0;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, k};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        exp_r = predict_table(op, k, v);
        if (check_fixed && exp_r != fixed)
            $display("%0t directed row disagrees with predictor: exp %h got %h",
                     $time, fixed, exp_r);
        result_q.push_back(check_fixed ? fixed : exp_r);
        @(negedge clk) s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic katm_pkg::katm_result_t mk(int cnt, logic [31:0] k, logic [31:0] v,
                                                  logic emp, logic drp);
        katm_pkg::katm_result_t r;
        r.entry_count = cnt[4:0];
        r.max_key     = k;
        r.max_value   = v;
        r.is_empty    = emp;
        r.dropped     = drp;
        return r;
    endfunction

    task automatic add_row(logic op, logic [31:0] k, logic [31:0] v,
                           bit chk, katm_pkg::katm_result_t fx);
        dir_row_t d;
        d.op = op; d.k = k; d.v = v; d.check_fixed = chk; d.fixed = fx;
        dir_rows.push_back(d);
    endtask

    // Result checker, sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            katm_pkg::katm_result_t got, exp_r;
            got = katm_pkg::katm_result_t'(m_axis_tdata[70:0]);
            if (result_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end
            else begin
                exp_r = result_q.pop_front();
                if (got.entry_count !== exp_r.entry_count) begin
                    $display("%0t entry_count exp %0d got %0d", $time,
                             exp_r.entry_count, got.entry_count);
                    errors++;
                end
                if (got.max_key !== exp_r.max_key) begin
                    $display("%0t max_key exp %h got %h", $time, exp_r.max_key, got.max_key);
                    errors++;
                end
                if (got.max_value !== exp_r.max_value) begin
                    $display("%0t max_value exp %h got %h", $time,
                             exp_r.max_value, got.max_value);
                    errors++;
                end
                if (got.is_empty !== exp_r.is_empty) begin
                    $display("%0t is_empty exp %b got %b", $time, exp_r.is_empty, got.is_empty);
                    errors++;
                end
                if (got.dropped !== exp_r.dropped) begin
                    $display("%0t dropped exp %b got %b", $time, exp_r.dropped, got.dropped);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            g = 0;
            if ($urandom_range(0, 2) == 0) g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        katm_pkg::katm_result_t none;
        logic op;
        logic [31:0] k, v;
        none = '0;
        errors = 0;
        cycles = 0;
        stim_done = 0;
        tbl_count = 0;
        for (int i = 0; i < katm_pkg::TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = katm_pkg::OP_ADD;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: empty table, extremes, wrap, ties, full table drop
        add_row(katm_pkg::OP_CLEAR, 32'h1234_5678, 32'h1, 1, mk(0, 0, 0, 1, 0));
        add_row(katm_pkg::OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 1,
                mk(1, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        add_row(katm_pkg::OP_ADD, 32'h8000_0000, 32'h1, 1,
                mk(1, 32'h8000_0000, 32'h8000_0000, 0, 0));
        add_row(katm_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 1,
                mk(2, 32'h8000_0000, 32'h8000_0000, 0, 0));
        add_row(katm_pkg::OP_ADD, 32'h0, 32'hffff_ffff, 1,
                mk(3, 32'h0, 32'hffff_ffff, 0, 0));
        add_row(katm_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 1,
                mk(4, 32'hffff_ffff, 32'hffff_ffff, 0, 0));
        add_row(katm_pkg::OP_CLEAR, 0, 0, 1, mk(0, 0, 0, 1, 0));
        for (int i = 0; i < katm_pkg::TABLE_DEPTH; i++)
            add_row(katm_pkg::OP_ADD, 100 - i, 5, 0, none);
        add_row(katm_pkg::OP_ADD, 32'h5555_5555, 32'h7fff_ffff, 1,
                mk(katm_pkg::TABLE_DEPTH, 32'd85, 32'd5, 0, 1));
        add_row(katm_pkg::OP_ADD, 32'd90, 32'hffff_ffff, 0, none);
        add_row(katm_pkg::OP_CLEAR, 0, 0, 1, mk(0, 0, 0, 1, 0));
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].k, dir_rows[i].v,
                         dir_rows[i].check_fixed, dir_rows[i].fixed);

        // Random: mostly adds on a small key pool so matches and fills occur
        for (int i = 0; i < 8; i++) key_pool[i] = rand_word();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0)
                for (int i = 0; i < 8; i++) key_pool[i] = rand_word();
            op = ($urandom_range(0, 39) == 0) ? katm_pkg::OP_CLEAR : katm_pkg::OP_ADD;
            case ($urandom_range(0, 3))
                0, 1: k = key_pool[$urandom_range(0, 7)];
                2: k = $urandom_range(0, 23);
                default: k = rand_word();
            endcase
            v = rand_word();
            send_request(op, k, v, 0, none);
        end
        stim_done = 1;

        while (result_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
hdl/katm_pkg.sv
hdl/katm_front.sv
hdl/katm_engine.sv
hdl/keyed_accumulate_table_with_max_unit.sv
dv/tb.sv
